// ----- rtl/ilst_pkg.sv -----
// Package for the indexed list store: field widths, request and status codes,
// and the operation type that the control logic hands to each list cell.
// No dependencies.
package ilst_pkg;

    localparam int VAL_W      = 64;
    localparam int POS_W      = 5;
    localparam int REQ_W      = 3;
    localparam int FOUND_W    = 4;
    localparam int STATUS_W   = 3;
    localparam int LEN_W      = 5;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 80;

    localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_GET     = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SEARCH  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DELETE  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_REVERSE = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_RANGE    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd4;

    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_LOAD  = 2'd1,
        CELL_SHL   = 2'd2,
        CELL_SHR   = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     in_use;
    } cell_ctl_t;

endpackage

// ----- rtl/ilst_cell.sv -----
// One cell of the list chain: holds one 64-bit entry, takes a new value from
// the load bus or a neighbor, and compares its entry with the search key.
// Depends on ilst_pkg.
module ilst_cell (
    input  logic                       aclk,
    input  ilst_pkg::cell_ctl_t        ctl,
    input  logic [ilst_pkg::VAL_W-1:0] load_data,
    input  logic [ilst_pkg::VAL_W-1:0] left_q,
    input  logic [ilst_pkg::VAL_W-1:0] right_q,
    input  logic [ilst_pkg::VAL_W-1:0] key,
    output logic [ilst_pkg::VAL_W-1:0] q,
    output logic                       match
);

    logic [ilst_pkg::VAL_W-1:0] data_reg;
    logic [ilst_pkg::VAL_W-1:0] data_next;
    logic                       key_nan;
    logic                       data_nan;
    logic                       both_zero;

    always_comb begin
        unique case (ctl.op)
            ilst_pkg::CELL_LOAD: data_next = load_data;
            ilst_pkg::CELL_SHL:  data_next = right_q;
            ilst_pkg::CELL_SHR:  data_next = left_q;
            default:             data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    // IEEE equality: NaN matches nothing, and the two zeros match each other.
    assign key_nan   = (&key[62:52]) && (|key[51:0]);
    assign data_nan  = (&data_reg[62:52]) && (|data_reg[51:0]);
    assign both_zero = ~|(key[62:0] | data_reg[62:0]);
    assign match     = ctl.in_use && !key_nan && !data_nan
                       && (both_zero || (key == data_reg));
    assign q         = data_reg;

endmodule

// ----- rtl/indexed_list_store_top.sv -----
// Top level of the indexed list store: a chain of list cells, the request
// control, the first-match search and the result register.
// Depends on ilst_pkg and ilst_cell.
//
//  Channel  Direction  Handshake                      Contents
//  s_axis   in         s_axis_tvalid / s_axis_tready  request: type, position, value
//  m_axis   out        m_axis_tvalid / m_axis_tready  result: value, position, status, length
//
// Insert, get, delete, unused codes and a reverse of at most one entry write the result
// register when the request is taken. Search first registers the parallel compare of the
// cells, then encodes the match vector. A longer reverse rotates the chain step by step
// in ST_REV, then reports from ST_FIN.
// Reset clears the length and the control state; the cell contents are not cleared.
// A request is taken only when the control is idle and the result register is free.
module indexed_list_store_top #(
    parameter int CAPACITY = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: position [4:0], item_value [68:5], zeros [71:69]
    input  logic [ilst_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // tuser: req_type [2:0]
    input  logic [ilst_pkg::REQ_W-1:0]          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: read_value [63:0], found_position [67:64], status [70:68],
    // length [75:71], zeros [79:76]
    output logic [ilst_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > ilst_pkg::POS_W) ? CNT_W : ilst_pkg::POS_W;
    localparam int RD_N  = (CAPACITY < 32) ? CAPACITY : 32;
    localparam int RD_W  = (RD_N > 1) ? $clog2(RD_N) : 1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SRCH = 4'b0010,
        ST_REV  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t                            state_reg;
    state_t                            state_next;
    logic [CNT_W-1:0]                  count_reg;
    logic [CNT_W-1:0]                  count_next;
    logic [IDX_W-1:0]                  hi_reg;
    logic [IDX_W-1:0]                  hi_next;
    logic [CAPACITY-1:0]               match_reg;
    logic                              out_valid_reg;
    logic [ilst_pkg::OUT_DATA_W-1:0]   out_data_reg;

    logic [ilst_pkg::REQ_W-1:0]        req;
    logic [ilst_pkg::POS_W-1:0]        pos;
    logic [ilst_pkg::VAL_W-1:0]        key;
    logic                              accept;
    logic                              out_free;
    logic [CMP_W-1:0]                  pos_c;
    logic [CMP_W-1:0]                  cnt_c;
    logic                              full;
    logic                              ins_ok;
    logic                              at_ok;
    logic                              insert_go;
    logic                              delete_go;
    logic [ilst_pkg::VAL_W-1:0]        load_data;
    logic [ilst_pkg::VAL_W-1:0]        rd_data;
    logic [IDX_W-1:0]                  first_idx;
    logic                              any_match;

    logic                              wr_res;
    logic [ilst_pkg::VAL_W-1:0]        res_value;
    logic [ilst_pkg::FOUND_W-1:0]      res_found;
    logic [ilst_pkg::STATUS_W-1:0]     res_status;
    logic [ilst_pkg::LEN_W-1:0]        res_len;

    logic [ilst_pkg::VAL_W-1:0]        cell_q     [CAPACITY];
    logic [CAPACITY-1:0]               cell_match;
    ilst_pkg::cell_ctl_t               cell_ctl   [CAPACITY];
    logic [ilst_pkg::VAL_W-1:0]        rd_win     [RD_N];

    assign req    = s_axis_tuser;
    assign pos    = s_axis_tdata[4:0];
    assign key    = s_axis_tdata[68:5];
    assign accept = s_axis_tvalid && s_axis_tready;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;

    assign pos_c     = CMP_W'(pos);
    assign cnt_c     = CMP_W'(count_reg);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign ins_ok    = (pos_c <= cnt_c);
    assign at_ok     = (pos_c < cnt_c);
    assign insert_go = accept && (req == ilst_pkg::REQ_INSERT) && ins_ok && !full;
    assign delete_go = accept && (req == ilst_pkg::REQ_DELETE) && at_ok;
    assign load_data = (state_reg == ST_REV) ? cell_q[0] : key;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [ilst_pkg::VAL_W-1:0] left_q;
            logic [ilst_pkg::VAL_W-1:0] right_q;

            if (gi == 0) begin : g_first
                assign left_q = '0;
            end else begin : g_mid_l
                assign left_q = cell_q[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_last
                assign right_q = '0;
            end else begin : g_mid_r
                assign right_q = cell_q[gi+1];
            end

            always_comb begin
                cell_ctl[gi].in_use = (CNT_W'(gi) < count_reg);
                cell_ctl[gi].op     = ilst_pkg::CELL_HOLD;
                if (insert_go) begin
                    if (CMP_W'(gi) == pos_c) begin
                        cell_ctl[gi].op = ilst_pkg::CELL_LOAD;
                    end else if (CMP_W'(gi) > pos_c) begin
                        cell_ctl[gi].op = ilst_pkg::CELL_SHR;
                    end
                end else if (delete_go) begin
                    if (CMP_W'(gi) >= pos_c) begin
                        cell_ctl[gi].op = ilst_pkg::CELL_SHL;
                    end
                end else if (state_reg == ST_REV) begin
                    if (IDX_W'(gi) == hi_reg) begin
                        cell_ctl[gi].op = ilst_pkg::CELL_LOAD;
                    end else if (IDX_W'(gi) < hi_reg) begin
                        cell_ctl[gi].op = ilst_pkg::CELL_SHL;
                    end
                end
            end

            ilst_cell u_cell (
                .aclk      (aclk),
                .ctl       (cell_ctl[gi]),
                .load_data (load_data),
                .left_q    (left_q),
                .right_q   (right_q),
                .key       (key),
                .q         (cell_q[gi]),
                .match     (cell_match[gi])
            );
        end

        for (gi = 0; gi < RD_N; gi++) begin : g_rd
            assign rd_win[gi] = cell_q[gi];
        end
    endgenerate

    assign rd_data = rd_win[pos[RD_W-1:0]];

    always_comb begin
        first_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (match_reg[i]) begin
                first_idx = IDX_W'(i);
            end
        end
    end

    assign any_match = |match_reg;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        hi_next    = hi_reg;
        wr_res     = 1'b0;
        res_value  = '0;
        res_found  = '0;
        res_status = ilst_pkg::STAT_OK;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    wr_res = 1'b1;
                    case (req)
                        ilst_pkg::REQ_INSERT: begin
                            if (!ins_ok) begin
                                res_status = ilst_pkg::STAT_RANGE;
                            end else if (full) begin
                                res_status = ilst_pkg::STAT_FULL;
                            end else begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        ilst_pkg::REQ_GET: begin
                            if (at_ok) begin
                                res_value = rd_data;
                            end else begin
                                res_status = ilst_pkg::STAT_RANGE;
                            end
                        end
                        ilst_pkg::REQ_SEARCH: begin
                            wr_res     = 1'b0;
                            state_next = ST_SRCH;
                        end
                        ilst_pkg::REQ_DELETE: begin
                            if (at_ok) begin
                                res_value  = rd_data;
                                count_next = count_reg - 1'b1;
                            end else begin
                                res_status = ilst_pkg::STAT_RANGE;
                            end
                        end
                        ilst_pkg::REQ_REVERSE: begin
                            if (count_reg == '0) begin
                                res_status = ilst_pkg::STAT_EMPTY;
                            end else if (count_reg != CNT_W'(1)) begin
                                wr_res     = 1'b0;
                                hi_next    = IDX_W'(count_reg - 1'b1);
                                state_next = ST_REV;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SRCH: begin
                if (out_free) begin
                    wr_res     = 1'b1;
                    state_next = ST_IDLE;
                    if (any_match) begin
                        res_found = ilst_pkg::FOUND_W'(first_idx);
                    end else begin
                        res_status = ilst_pkg::STAT_NOTFOUND;
                    end
                end
            end
            ST_REV: begin
                hi_next = hi_reg - 1'b1;
                if (hi_reg == IDX_W'(1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    wr_res     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        res_len = ilst_pkg::LEN_W'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            hi_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            hi_reg    <= hi_next;
            if (wr_res) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            match_reg <= cell_match;
        end
        if (wr_res) begin
            out_data_reg <= {4'd0, res_len, res_status, res_found, res_value};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_count_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("list length exceeds capacity");

    a_single_cycle_result : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (req != ilst_pkg::REQ_SEARCH)
         && !((req == ilst_pkg::REQ_REVERSE) && (count_reg > CNT_W'(1))))
        |=> m_axis_tvalid)
        else $error("single-cycle request produced no result");

    a_rev_index : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REV) |-> ((hi_reg != '0) && (CNT_W'(hi_reg) < count_reg)))
        else $error("reverse step index out of range");

    a_busy_no_accept : assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_REV) || (state_reg == ST_FIN)) |-> $stable(count_reg))
        else $error("length changed during reverse");

endmodule

// ----- verif/indexed_list_store_checker.sv -----
`timescale 1ns / 100ps
// Checker for the indexed list store: it watches both stream channels, keeps its
// own copy of the list and compares every result with the predicted one.
// Depends on ilst_pkg.
module indexed_list_store_checker #(
    parameter int CAPACITY = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [ilst_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  logic [ilst_pkg::REQ_W-1:0]          s_axis_tuser,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [ilst_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output int                                  error_count,
    output int                                  results_pending,
    output logic [ilst_pkg::LEN_W-1:0]          list_length
);

    typedef struct packed {
        logic [ilst_pkg::VAL_W-1:0]    read_value;
        logic [ilst_pkg::FOUND_W-1:0]  found_position;
        logic [ilst_pkg::STATUS_W-1:0] status;
        logic [ilst_pkg::LEN_W-1:0]    length;
    } list_result_t;

    localparam int MAX_REPORTS = 10;

    logic [ilst_pkg::VAL_W-1:0] cells [CAPACITY];
    int                         entry_total;
    list_result_t               expected_q [$];
    list_result_t               got;
    list_result_t               want;

    function automatic logic is_nan_pattern(input logic [ilst_pkg::VAL_W-1:0] v);
        return (&v[62:52]) && (|v[51:0]);
    endfunction

    // IEEE equality on raw patterns: NaN matches nothing, and both zeros are equal.
    function automatic logic same_double(input logic [ilst_pkg::VAL_W-1:0] a,
                                         input logic [ilst_pkg::VAL_W-1:0] b);
        if (is_nan_pattern(a) || is_nan_pattern(b)) begin
            return 1'b0;
        end
        if ((a[62:0] | b[62:0]) == '0) begin
            return 1'b1;
        end
        return a == b;
    endfunction

    function automatic list_result_t apply_request(input logic [ilst_pkg::REQ_W-1:0] req,
                                                   input logic [ilst_pkg::POS_W-1:0] pos,
                                                   input logic [ilst_pkg::VAL_W-1:0] val);
        list_result_t               res;
        int                         p;
        int                         i;
        int                         lo;
        int                         hi;
        logic [ilst_pkg::VAL_W-1:0] held;
        res = '0;
        p = int'(pos);
        case (req)
            ilst_pkg::REQ_INSERT: begin
                if (p > entry_total) begin
                    res.status = ilst_pkg::STAT_RANGE;
                end else if (entry_total >= CAPACITY) begin
                    res.status = ilst_pkg::STAT_FULL;
                end else begin
                    for (i = entry_total; i > p; i--) begin
                        cells[i] = cells[i-1];
                    end
                    cells[p] = val;
                    entry_total++;
                end
            end
            ilst_pkg::REQ_GET: begin
                if (p >= entry_total) begin
                    res.status = ilst_pkg::STAT_RANGE;
                end else begin
                    res.read_value = cells[p];
                end
            end
            ilst_pkg::REQ_SEARCH: begin
                res.status = ilst_pkg::STAT_NOTFOUND;
                for (i = 0; i < entry_total; i++) begin
                    if (res.status == ilst_pkg::STAT_NOTFOUND && same_double(val, cells[i])) begin
                        res.found_position = ilst_pkg::FOUND_W'(i);
                        res.status = ilst_pkg::STAT_OK;
                    end
                end
            end
            ilst_pkg::REQ_DELETE: begin
                if (p >= entry_total) begin
                    res.status = ilst_pkg::STAT_RANGE;
                end else begin
                    res.read_value = cells[p];
                    for (i = p; i + 1 < entry_total; i++) begin
                        cells[i] = cells[i+1];
                    end
                    entry_total--;
                end
            end
            ilst_pkg::REQ_REVERSE: begin
                if (entry_total == 0) begin
                    res.status = ilst_pkg::STAT_EMPTY;
                end else begin
                    lo = 0;
                    hi = entry_total - 1;
                    while (lo < hi) begin
                        held = cells[lo];
                        cells[lo] = cells[hi];
                        cells[hi] = held;
                        lo++;
                        hi--;
                    end
                end
            end
            default: begin
            end
        endcase
        res.length = ilst_pkg::LEN_W'(entry_total);
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            entry_total = 0;
            error_count = 0;
            expected_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.read_value     = m_axis_tdata[63:0];
                got.found_position = m_axis_tdata[67:64];
                got.status         = m_axis_tdata[70:68];
                got.length         = m_axis_tdata[75:71];
                if (expected_q.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display({"%0t: result transaction with none expected: ",
                                  "value %h pos %0d status %0d length %0d"},
                                 $realtime, got.read_value, got.found_position, got.status,
                                 got.length);
                    end
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS) begin
                            $display({"%0t: result mismatch: expected ",
                                      "value %h pos %0d status %0d length %0d"},
                                     $realtime, want.read_value, want.found_position,
                                     want.status, want.length);
                            $display({"%0t:                  actual   ",
                                      "value %h pos %0d status %0d length %0d"},
                                     $realtime, got.read_value, got.found_position,
                                     got.status, got.length);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_q.push_back(apply_request(
                    s_axis_tuser, s_axis_tdata[ilst_pkg::POS_W-1:0],
                    s_axis_tdata[ilst_pkg::POS_W+ilst_pkg::VAL_W-1:ilst_pkg::POS_W]));
            end
        end
        results_pending = expected_q.size();
        list_length = ilst_pkg::LEN_W'(entry_total);
    end

endmodule

// ----- verif/indexed_list_store_top_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the indexed list store: clock, reset, request stimulus,
// receiver stalls and the final verdict.
// Depends on ilst_pkg, indexed_list_store_top and indexed_list_store_checker.
module indexed_list_store_top_tb;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_ITEMS = 1700;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 2 * CAPACITY;

    localparam logic [ilst_pkg::REQ_W-1:0] REQ_SPARE_FIRST = 3'd5;
    localparam logic [ilst_pkg::REQ_W-1:0] REQ_SPARE_LAST  = 3'd7;

    localparam int PHASE_GROW   = 0;
    localparam int PHASE_SHRINK = 1;
    localparam int PHASE_MIXED  = 2;

    localparam logic [ilst_pkg::VAL_W-1:0] POS_ZERO_BITS  = 64'h0000_0000_0000_0000;
    localparam logic [ilst_pkg::VAL_W-1:0] NEG_ZERO_BITS  = 64'h8000_0000_0000_0000;
    localparam logic [ilst_pkg::VAL_W-1:0] QNAN_BITS      = 64'h7FF8_0000_0000_0000;
    localparam logic [ilst_pkg::VAL_W-1:0] SNAN_BITS      = 64'h7FF0_0000_0000_0001;
    localparam logic [ilst_pkg::VAL_W-1:0] POS_INF_BITS   = 64'h7FF0_0000_0000_0000;
    localparam logic [ilst_pkg::VAL_W-1:0] NEG_INF_BITS   = 64'hFFF0_0000_0000_0000;
    localparam logic [ilst_pkg::VAL_W-1:0] ONE_BITS       = 64'h3FF0_0000_0000_0000;
    localparam logic [ilst_pkg::VAL_W-1:0] MINUS_ONE_BITS = 64'hBFF0_0000_0000_0000;
    localparam logic [ilst_pkg::VAL_W-1:0] ALL_ONES_BITS  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [ilst_pkg::VAL_W-1:0] DENORMAL_BITS  = 64'h0000_0000_0000_0001;

    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [ilst_pkg::IN_DATA_W-1:0]     s_axis_tdata = '0;
    logic [ilst_pkg::REQ_W-1:0]         s_axis_tuser = '0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [ilst_pkg::OUT_DATA_W-1:0]    m_axis_tdata;

    int                                 error_count;
    int                                 results_pending;
    logic [ilst_pkg::LEN_W-1:0]         list_length;

    int                                 cycle_count = 0;
    int                                 ready_mode = 0;
    int                                 ready_phase_left = 0;
    logic [ilst_pkg::VAL_W-1:0]         recent_vals [8];
    int                                 recent_wr = 0;

    indexed_list_store_top #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    indexed_list_store_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .error_count     (error_count),
        .results_pending (results_pending),
        .list_length     (list_length)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("indexed_list_store_top_tb failed");
            $finish;
        end
    end

    // The receiver switches between always ready, coin flips, long stalls and a
    // fixed one-in-five pattern.
    always @(negedge aclk) begin
        if (ready_phase_left == 0) begin
            ready_mode <= int'($urandom_range(0, 3));
            ready_phase_left <= int'($urandom_range(16, 96));
        end else begin
            ready_phase_left <= ready_phase_left - 1;
        end
        case (ready_mode)
            0: begin
                m_axis_tready <= 1'b1;
            end
            1: begin
                m_axis_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_axis_tready <= ($urandom_range(0, 7) == 0);
            end
            default: begin
                m_axis_tready <= (ready_phase_left % 5 == 0);
            end
        endcase
    end

    function automatic logic [ilst_pkg::VAL_W-1:0] special_value(input int idx);
        case (idx)
            0: return POS_ZERO_BITS;
            1: return NEG_ZERO_BITS;
            2: return QNAN_BITS;
            3: return SNAN_BITS;
            4: return POS_INF_BITS;
            5: return NEG_INF_BITS;
            6: return ONE_BITS;
            7: return MINUS_ONE_BITS;
            8: return ALL_ONES_BITS;
            9: return DENORMAL_BITS;
            default: return {1'b1, QNAN_BITS[62:0]};
        endcase
    endfunction

    function automatic logic [ilst_pkg::VAL_W-1:0] pick_value();
        if ($urandom_range(0, 9) < 4) begin
            return special_value(int'($urandom_range(0, 10)));
        end
        return {$urandom(), $urandom()};
    endfunction

    // Drives one request, to be called at a falling edge, and returns at the
    // rising edge where the transaction is accepted.
    task automatic drive_and_wait(input logic [ilst_pkg::REQ_W-1:0] req,
                                  input logic [ilst_pkg::POS_W-1:0] pos,
                                  input logic [ilst_pkg::VAL_W-1:0] val);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= req;
        s_axis_tdata <= {{(ilst_pkg::IN_DATA_W-ilst_pkg::VAL_W-ilst_pkg::POS_W){1'b0}},
                         val, pos};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic issue_request(input logic [ilst_pkg::REQ_W-1:0] req,
                                 input logic [ilst_pkg::POS_W-1:0] pos,
                                 input logic [ilst_pkg::VAL_W-1:0] val);
        @(negedge aclk);
        drive_and_wait(req, pos, val);
    endtask

    // Picks the operation from the phase mix and the position from the current
    // list length, so that most requests land inside the list.
    task automatic issue_random_request(input int phase);
        logic [ilst_pkg::REQ_W-1:0] req;
        logic [ilst_pkg::POS_W-1:0] pos;
        logic [ilst_pkg::VAL_W-1:0] val;
        int                         pick;
        int                         len;
        int                         ins_lim;
        int                         get_lim;
        int                         srch_lim;
        int                         del_lim;
        @(negedge aclk);
        len = int'(list_length);
        case (phase)
            PHASE_GROW: begin
                ins_lim = 55; get_lim = 67; srch_lim = 82; del_lim = 94;
            end
            PHASE_SHRINK: begin
                ins_lim = 20; get_lim = 32; srch_lim = 50; del_lim = 90;
            end
            default: begin
                ins_lim = 35; get_lim = 50; srch_lim = 70; del_lim = 90;
            end
        endcase
        pick = int'($urandom_range(0, 99));
        if (pick < ins_lim) begin
            req = ilst_pkg::REQ_INSERT;
        end else if (pick < get_lim) begin
            req = ilst_pkg::REQ_GET;
        end else if (pick < srch_lim) begin
            req = ilst_pkg::REQ_SEARCH;
        end else if (pick < del_lim) begin
            req = ilst_pkg::REQ_DELETE;
        end else if (pick < 98) begin
            req = ilst_pkg::REQ_REVERSE;
        end else begin
            req = ilst_pkg::REQ_W'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
        end
        pos = ilst_pkg::POS_W'($urandom_range(0, (1 << ilst_pkg::POS_W) - 1));
        val = {$urandom(), $urandom()};
        if (req == ilst_pkg::REQ_INSERT) begin
            if ($urandom_range(0, 99) < 85) begin
                pos = ilst_pkg::POS_W'($urandom_range(0, len));
            end
            val = pick_value();
            recent_vals[recent_wr] = val;
            recent_wr = (recent_wr + 1) % 8;
        end else if (req == ilst_pkg::REQ_GET || req == ilst_pkg::REQ_DELETE) begin
            if (len > 0 && $urandom_range(0, 99) < 85) begin
                pos = ilst_pkg::POS_W'($urandom_range(0, len - 1));
            end
        end else if (req == ilst_pkg::REQ_SEARCH) begin
            val = ($urandom_range(0, 1) == 1) ? recent_vals[$urandom_range(0, 7)]
                                               : pick_value();
        end
        drive_and_wait(req, pos, val);
    endtask

    initial begin
        int n;
        int phase;
        int burst_left;
        int gap;
        phase = PHASE_GROW;
        burst_left = 0;
        for (n = 0; n < 8; n++) begin
            recent_vals[n] = '0;
        end
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Empty list: reverse, get, delete and search each meet their empty case.
        issue_request(ilst_pkg::REQ_REVERSE, 5'd0, '0);
        issue_request(ilst_pkg::REQ_GET, 5'd0, '0);
        issue_request(ilst_pkg::REQ_DELETE, 5'd0, '0);
        issue_request(ilst_pkg::REQ_SEARCH, 5'd0, POS_ZERO_BITS);
        issue_request(ilst_pkg::REQ_INSERT, 5'd1, ONE_BITS);
        issue_request(ilst_pkg::REQ_INSERT, 5'd0, POS_ZERO_BITS);
        issue_request(ilst_pkg::REQ_REVERSE, 5'd0, '0);
        issue_request(ilst_pkg::REQ_INSERT, 5'd1, NEG_ZERO_BITS);
        issue_request(ilst_pkg::REQ_INSERT, 5'd2, QNAN_BITS);
        issue_request(ilst_pkg::REQ_INSERT, 5'd0, ONE_BITS);
        issue_request(ilst_pkg::REQ_INSERT, 5'd4, ALL_ONES_BITS);
        // Signed zeros match each other, while NaN and a missing key do not match.
        issue_request(ilst_pkg::REQ_SEARCH, 5'd0, NEG_ZERO_BITS);
        issue_request(ilst_pkg::REQ_SEARCH, 5'd0, QNAN_BITS);
        issue_request(ilst_pkg::REQ_SEARCH, 5'd0, POS_INF_BITS);
        issue_request(ilst_pkg::REQ_REVERSE, 5'd0, '0);
        issue_request(ilst_pkg::REQ_GET, 5'd4, '0);
        issue_request(ilst_pkg::REQ_GET, 5'd16, '0);
        issue_request(ilst_pkg::REQ_DELETE, 5'd5, '0);
        issue_request(ilst_pkg::REQ_DELETE, 5'd0, '0);
        issue_request(REQ_SPARE_LAST, 5'd31, ALL_ONES_BITS);
        for (n = 0; n < CAPACITY - 4; n++) begin
            issue_request(ilst_pkg::REQ_INSERT, ilst_pkg::POS_W'($urandom_range(0, 4 + n)),
                          pick_value());
        end
        // A full list rejects an insert, but a bad position is reported first.
        issue_request(ilst_pkg::REQ_INSERT, 5'd16, ONE_BITS);
        issue_request(ilst_pkg::REQ_INSERT, 5'd17, ONE_BITS);
        issue_request(ilst_pkg::REQ_SEARCH, 5'd0, ONE_BITS);
        issue_request(ilst_pkg::REQ_DELETE, 5'd15, '0);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 48 == 0) begin
                phase = int'($urandom_range(PHASE_GROW, PHASE_MIXED));
            end
            if (burst_left == 0) begin
                burst_left = int'($urandom_range(1, 24));
                if ($urandom_range(0, 3) != 0) begin
                    gap = int'($urandom_range(1, 6));
                    repeat (gap) begin
                        @(negedge aclk);
                        s_axis_tvalid <= 1'b0;
                    end
                end
            end
            burst_left--;
            issue_random_request(phase);
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;

        while (results_pending != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && results_pending == 0) begin
            $display("indexed_list_store_top_tb passed");
        end else begin
            $display("indexed_list_store_top_tb failed");
        end
        $finish;
    end

endmodule
